// ===== rtl/calculator_token_scanner_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the calculator token scanner
// Clocked, reset-qualified forms of the same-cycle and next-cycle properties.
// ----------------------------------------------------------------------------
`ifndef CALCULATOR_TOKEN_SCANNER_ASSERT_SVH
`define CALCULATOR_TOKEN_SCANNER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define CTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cts_pkg.sv =====
// ----------------------------------------------------------------------------
// cts_pkg
// Shared widths, token codes, scanner state and result types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cts_pkg;

    localparam int CHAR_W  = 8;
    localparam int KIND_W  = 5;
    localparam int LINE_W  = 16;
    localparam int LEN_W   = 8;
    localparam int LIT_W   = 32;
    localparam int OFF_W   = 32;
    localparam int KW_W    = 40;
    localparam int PROD_W  = LIT_W + 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QIDX_W + 1;
    localparam int PUSH_W      = 2;

    // Character constants
    localparam logic [CHAR_W-1:0] CH_COLON   = ":";
    localparam logic [CHAR_W-1:0] CH_EQUAL   = "=";
    localparam logic [CHAR_W-1:0] CH_LESS    = "<";
    localparam logic [CHAR_W-1:0] CH_GREATER = ">";
    localparam logic [CHAR_W-1:0] CH_UNDER   = "_";
    localparam logic [CHAR_W-1:0] CH_SPACE   = " ";
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF      = 8'd10;
    localparam logic [CHAR_W-1:0] CH_ZERO    = "0";
    localparam logic [CHAR_W-1:0] CH_NINE    = "9";
    localparam logic [CHAR_W-1:0] CH_LO_A    = "a";
    localparam logic [CHAR_W-1:0] CH_LO_Z    = "z";
    localparam logic [CHAR_W-1:0] CH_UP_A    = "A";
    localparam logic [CHAR_W-1:0] CH_UP_Z    = "Z";
    localparam logic [CHAR_W-1:0] CH_PLUS    = "+";
    localparam logic [CHAR_W-1:0] CH_MINUS   = "-";
    localparam logic [CHAR_W-1:0] CH_STAR    = "*";
    localparam logic [CHAR_W-1:0] CH_SLASH   = "/";
    localparam logic [CHAR_W-1:0] CH_LPAREN  = "(";
    localparam logic [CHAR_W-1:0] CH_RPAREN  = ")";

    // Keyword spellings, first character in the high byte
    localparam logic [15:0]   KW_IF    = "if";
    localparam logic [15:0]   KW_FI    = "fi";
    localparam logic [15:0]   KW_DO    = "do";
    localparam logic [15:0]   KW_OD    = "od";
    localparam logic [31:0]   KW_READ  = "read";
    localparam logic [KW_W-1:0] KW_WRITE = "write";
    localparam logic [KW_W-1:0] KW_CHECK = "check";

    typedef enum logic [KIND_W-1:0] {
        K_ERROR   = 5'd0,
        K_ID      = 5'd1,
        K_LITERAL = 5'd2,
        K_GETS    = 5'd3,
        K_PLUS    = 5'd4,
        K_MINUS   = 5'd5,
        K_TIMES   = 5'd6,
        K_DIVIDE  = 5'd7,
        K_LPAREN  = 5'd8,
        K_RPAREN  = 5'd9,
        K_EQ      = 5'd10,
        K_NE      = 5'd11,
        K_LT      = 5'd12,
        K_LE      = 5'd13,
        K_GT      = 5'd14,
        K_GE      = 5'd15,
        K_IF      = 5'd16,
        K_FI      = 5'd17,
        K_DO      = 5'd18,
        K_OD      = 5'd19,
        K_READ    = 5'd20,
        K_WRITE   = 5'd21,
        K_CHECK   = 5'd22,
        K_END     = 5'd23
    } t_kind;

    // What the scanner is in the middle of
    typedef enum logic [6:0] {
        M_IDLE    = 7'b0000001,
        M_IDENT   = 7'b0000010,
        M_NUM     = 7'b0000100,
        M_COLON   = 7'b0001000,
        M_EQUAL   = 7'b0010000,
        M_LESS    = 7'b0100000,
        M_GREATER = 7'b1000000
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [KW_W-1:0]    kw_window;
        logic [LEN_W-1:0]   text_len;
        logic [LIT_W-1:0]   lit_acc;
        logic [LINE_W-1:0]  line_count;
        logic [OFF_W-1:0]   char_offset;
    } t_scan_state;

    localparam t_scan_state SCAN_RESET = '{
        mode:        M_IDLE,
        kw_window:   '0,
        text_len:    '0,
        lit_acc:     '0,
        line_count:  LINE_W'(1),
        char_offset: '0
    };

    typedef struct packed {
        logic [KIND_W-1:0]  token_kind;
        logic [LINE_W-1:0]  token_line;
        logic [LEN_W-1:0]   token_length;
        logic [LIT_W-1:0]   literal_value;
        logic [OFF_W-1:0]   token_end_offset;
        logic               last_result;
    } t_token;

    // Up to two tokens written to the result queue in one cycle
    typedef struct packed {
        logic [PUSH_W-1:0]  count;
        t_token             tok0;
        t_token             tok1;
    } t_push;

endpackage

`default_nettype wire

// ===== rtl/cts_char_if.sv =====
// ----------------------------------------------------------------------------
// cts_char_if
// Character channel: one byte or an end-of-input mark per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cts_char_if;
    logic                        valid;
    logic                        ready;
    logic [cts_pkg::CHAR_W-1:0]  char_code;
    logic                        end_of_input;

    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

`default_nettype wire

// ===== rtl/cts_token_if.sv =====
// ----------------------------------------------------------------------------
// cts_token_if
// Token channel: one scanned token per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cts_token_if;
    logic                        valid;
    logic                        ready;
    logic [cts_pkg::KIND_W-1:0]  token_kind;
    logic [cts_pkg::LINE_W-1:0]  token_line;
    logic [cts_pkg::LEN_W-1:0]   token_length;
    logic [cts_pkg::LIT_W-1:0]   literal_value;
    logic [cts_pkg::OFF_W-1:0]   token_end_offset;
    logic                        last_result;

    modport source (output valid, output token_kind, output token_line,
                    output token_length, output literal_value,
                    output token_end_offset, output last_result, input ready);
    modport sink   (input valid, input token_kind, input token_line,
                    input token_length, input literal_value,
                    input token_end_offset, input last_result, output ready);
endinterface

`default_nettype wire

// ===== rtl/cts_lex.sv =====
// ----------------------------------------------------------------------------
// cts_lex
// Next-state and token logic for one character against the scanner state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cts_lex (
    input  var cts_pkg::t_scan_state         i_state,
    input  var logic [cts_pkg::CHAR_W-1:0]   i_char_code,
    input  var logic                         i_end_of_input,
    output cts_pkg::t_scan_state             o_state,
    output cts_pkg::t_push                   o_push
);

    function automatic cts_pkg::t_token mk_tok(
        input logic [cts_pkg::KIND_W-1:0] kind,
        input logic [cts_pkg::LEN_W-1:0]  len,
        input logic [cts_pkg::LIT_W-1:0]  lit,
        input logic [cts_pkg::OFF_W-1:0]  off,
        input logic [cts_pkg::LINE_W-1:0] line
    );
        cts_pkg::t_token t;
        t.token_kind       = kind;
        t.token_line       = line;
        t.token_length     = len;
        t.literal_value    = lit;
        t.token_end_offset = off;
        t.last_result      = 1'b0;
        return t;
    endfunction

    logic [cts_pkg::CHAR_W-1:0]  c;
    logic                        is_space;
    logic                        is_alpha;
    logic                        is_digit;
    logic                        is_word;
    logic [3:0]                  digit;
    logic [cts_pkg::PROD_W-1:0]  acc_wide;
    logic [cts_pkg::LIT_W-1:0]   acc_next;
    logic [cts_pkg::LINE_W-1:0]  line_now;
    logic [cts_pkg::OFF_W-1:0]   off_next;
    logic [cts_pkg::KIND_W-1:0]  ident_kind;
    logic [cts_pkg::KIND_W-1:0]  op_kind;
    logic                        a_vld;
    logic                        b_vld;
    logic                        start;
    cts_pkg::t_token             a_tok;
    cts_pkg::t_token             b_tok;

    // Classify the character
    assign c        = i_char_code;
    assign is_space = (c == cts_pkg::CH_SPACE) ||
                      ((c >= cts_pkg::CH_TAB) && (c <= cts_pkg::CH_CR));
    assign is_alpha = ((c >= cts_pkg::CH_LO_A) && (c <= cts_pkg::CH_LO_Z)) ||
                      ((c >= cts_pkg::CH_UP_A) && (c <= cts_pkg::CH_UP_Z));
    assign is_digit = (c >= cts_pkg::CH_ZERO) && (c <= cts_pkg::CH_NINE);
    assign is_word  = is_alpha || is_digit || (c == cts_pkg::CH_UNDER);
    assign digit    = 4'(c - cts_pkg::CH_ZERO);

    // Accumulate a decimal digit, saturating on overflow
    assign acc_wide = (cts_pkg::PROD_W'(i_state.lit_acc) << 3)
                    + (cts_pkg::PROD_W'(i_state.lit_acc) << 1)
                    + cts_pkg::PROD_W'(digit);
    assign acc_next = (acc_wide[cts_pkg::PROD_W-1:cts_pkg::LIT_W] != '0)
                    ? '1 : acc_wide[cts_pkg::LIT_W-1:0];

    // A newline carried by this character counts before any token goes out
    assign line_now = ((c == cts_pkg::CH_LF) && (i_state.line_count != '1))
                    ? i_state.line_count + cts_pkg::LINE_W'(1)
                    : i_state.line_count;
    assign off_next = i_state.char_offset + cts_pkg::OFF_W'(1);

    // Keyword lookup on the last identifier characters
    always_comb begin
        ident_kind = cts_pkg::K_ID;
        case (i_state.text_len)
            cts_pkg::LEN_W'(2): begin
                if (i_state.kw_window[15:0] == cts_pkg::KW_IF) begin
                    ident_kind = cts_pkg::K_IF;
                end else if (i_state.kw_window[15:0] == cts_pkg::KW_FI) begin
                    ident_kind = cts_pkg::K_FI;
                end else if (i_state.kw_window[15:0] == cts_pkg::KW_DO) begin
                    ident_kind = cts_pkg::K_DO;
                end else if (i_state.kw_window[15:0] == cts_pkg::KW_OD) begin
                    ident_kind = cts_pkg::K_OD;
                end
            end
            cts_pkg::LEN_W'(4): begin
                if (i_state.kw_window[31:0] == cts_pkg::KW_READ) begin
                    ident_kind = cts_pkg::K_READ;
                end
            end
            cts_pkg::LEN_W'(5): begin
                if (i_state.kw_window == cts_pkg::KW_WRITE) begin
                    ident_kind = cts_pkg::K_WRITE;
                end else if (i_state.kw_window == cts_pkg::KW_CHECK) begin
                    ident_kind = cts_pkg::K_CHECK;
                end
            end
            default: ident_kind = cts_pkg::K_ID;
        endcase
    end

    // Single-character operators; anything unknown is an error
    always_comb begin
        case (c)
            cts_pkg::CH_PLUS:   op_kind = cts_pkg::K_PLUS;
            cts_pkg::CH_MINUS:  op_kind = cts_pkg::K_MINUS;
            cts_pkg::CH_STAR:   op_kind = cts_pkg::K_TIMES;
            cts_pkg::CH_SLASH:  op_kind = cts_pkg::K_DIVIDE;
            cts_pkg::CH_LPAREN: op_kind = cts_pkg::K_LPAREN;
            cts_pkg::CH_RPAREN: op_kind = cts_pkg::K_RPAREN;
            default:            op_kind = cts_pkg::K_ERROR;
        endcase
    end

    // Close the pending token, then scan the character afresh where needed
    always_comb begin
        o_state = i_state;
        a_vld   = 1'b0;
        b_vld   = 1'b0;
        start   = 1'b0;
        a_tok   = '0;
        b_tok   = '0;

        if (i_end_of_input) begin
            // Flush what is pending, then mark the end and drop all state
            case (i_state.mode)
                cts_pkg::M_IDENT: begin
                    a_vld = 1'b1;
                    a_tok = mk_tok(ident_kind, i_state.text_len, '0,
                                   i_state.char_offset, i_state.line_count);
                end
                cts_pkg::M_NUM: begin
                    a_vld = 1'b1;
                    a_tok = mk_tok(cts_pkg::K_LITERAL, i_state.text_len, i_state.lit_acc,
                                   i_state.char_offset, i_state.line_count);
                end
                cts_pkg::M_COLON, cts_pkg::M_EQUAL, cts_pkg::M_LESS,
                cts_pkg::M_GREATER: begin
                    a_vld = 1'b1;
                    a_tok = mk_tok(cts_pkg::K_ERROR, cts_pkg::LEN_W'(1), '0,
                                   i_state.char_offset, i_state.line_count);
                end
                default: a_vld = 1'b0;
            endcase
            b_vld   = 1'b1;
            b_tok   = mk_tok(cts_pkg::K_END, '0, '0, i_state.char_offset,
                             i_state.line_count);
            o_state = cts_pkg::SCAN_RESET;
        end else begin
            o_state.line_count  = line_now;
            o_state.char_offset = (i_state.char_offset == '1)
                                ? i_state.char_offset : off_next;

            case (i_state.mode)
                cts_pkg::M_IDENT: begin
                    if (is_word) begin
                        if (i_state.text_len != '1) begin
                            o_state.text_len = i_state.text_len + cts_pkg::LEN_W'(1);
                        end
                        o_state.kw_window = {i_state.kw_window[cts_pkg::KW_W-9:0], c};
                    end else begin
                        a_vld = 1'b1;
                        a_tok = mk_tok(ident_kind, i_state.text_len, '0,
                                       i_state.char_offset, line_now);
                        start = 1'b1;
                    end
                end
                cts_pkg::M_NUM: begin
                    if (is_digit) begin
                        if (i_state.text_len != '1) begin
                            o_state.text_len = i_state.text_len + cts_pkg::LEN_W'(1);
                        end
                        o_state.lit_acc = acc_next;
                    end else begin
                        a_vld = 1'b1;
                        a_tok = mk_tok(cts_pkg::K_LITERAL, i_state.text_len,
                                       i_state.lit_acc, i_state.char_offset, line_now);
                        start = 1'b1;
                    end
                end
                cts_pkg::M_COLON, cts_pkg::M_EQUAL: begin
                    a_vld = 1'b1;
                    if (c == cts_pkg::CH_EQUAL) begin
                        a_tok = mk_tok((i_state.mode == cts_pkg::M_COLON)
                                       ? cts_pkg::K_GETS : cts_pkg::K_EQ,
                                       cts_pkg::LEN_W'(2), '0, off_next, line_now);
                        o_state.mode = cts_pkg::M_IDLE;
                    end else begin
                        a_tok = mk_tok(cts_pkg::K_ERROR, cts_pkg::LEN_W'(2), '0,
                                       i_state.char_offset, line_now);
                        start = 1'b1;
                    end
                end
                cts_pkg::M_LESS, cts_pkg::M_GREATER: begin
                    a_vld        = 1'b1;
                    o_state.mode = cts_pkg::M_IDLE;
                    if ((i_state.mode == cts_pkg::M_LESS) && (c == cts_pkg::CH_GREATER)) begin
                        a_tok = mk_tok(cts_pkg::K_NE, cts_pkg::LEN_W'(2), '0,
                                       off_next, line_now);
                    end else if (c == cts_pkg::CH_EQUAL) begin
                        a_tok = mk_tok((i_state.mode == cts_pkg::M_LESS)
                                       ? cts_pkg::K_LE : cts_pkg::K_GE,
                                       cts_pkg::LEN_W'(2), '0, off_next, line_now);
                    end else if (c == cts_pkg::CH_SPACE) begin
                        // Lone comparison: the space is swallowed
                        a_tok = mk_tok((i_state.mode == cts_pkg::M_LESS)
                                       ? cts_pkg::K_LT : cts_pkg::K_GT,
                                       cts_pkg::LEN_W'(1), '0, i_state.char_offset,
                                       line_now);
                    end else begin
                        a_tok = mk_tok(cts_pkg::K_ERROR, cts_pkg::LEN_W'(2), '0,
                                       i_state.char_offset, line_now);
                        start = 1'b1;
                    end
                end
                default: start = 1'b1;
            endcase

            // Fresh scan of the character
            if (start) begin
                o_state.mode      = cts_pkg::M_IDLE;
                o_state.text_len  = '0;
                o_state.lit_acc   = '0;
                o_state.kw_window = '0;
                if (is_space) begin
                    o_state.mode = cts_pkg::M_IDLE;
                end else if (is_alpha) begin
                    o_state.mode      = cts_pkg::M_IDENT;
                    o_state.text_len  = cts_pkg::LEN_W'(1);
                    o_state.kw_window = cts_pkg::KW_W'(c);
                end else if (is_digit) begin
                    o_state.mode     = cts_pkg::M_NUM;
                    o_state.text_len = cts_pkg::LEN_W'(1);
                    o_state.lit_acc  = cts_pkg::LIT_W'(digit);
                end else if (c == cts_pkg::CH_COLON) begin
                    o_state.mode = cts_pkg::M_COLON;
                end else if (c == cts_pkg::CH_EQUAL) begin
                    o_state.mode = cts_pkg::M_EQUAL;
                end else if (c == cts_pkg::CH_LESS) begin
                    o_state.mode = cts_pkg::M_LESS;
                end else if (c == cts_pkg::CH_GREATER) begin
                    o_state.mode = cts_pkg::M_GREATER;
                end else begin
                    b_vld = 1'b1;
                    b_tok = mk_tok(op_kind, cts_pkg::LEN_W'(1), '0, off_next, line_now);
                end
            end
        end
    end

    // Pack the tokens in order and flag the final one
    always_comb begin
        o_push      = '0;
        o_push.tok1 = b_tok;
        if (a_vld) begin
            o_push.tok0 = a_tok;
            if (b_vld) begin
                o_push.count            = cts_pkg::PUSH_W'(2);
                o_push.tok1.last_result = 1'b1;
            end else begin
                o_push.count            = cts_pkg::PUSH_W'(1);
                o_push.tok0.last_result = 1'b1;
            end
        end else begin
            o_push.tok0 = b_tok;
            o_push.tok0.last_result = 1'b1;
            o_push.count = b_vld ? cts_pkg::PUSH_W'(1) : '0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cts_queue.sv =====
// ----------------------------------------------------------------------------
// cts_queue
// Result queue: takes up to two tokens a cycle, hands out one a cycle while the reader is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cts_queue (
    input  var logic              i_clk,
    input  var logic              i_rst_n,
    input  var cts_pkg::t_push    i_push,
    output logic                  o_room,
    input  var logic              i_pop_ready,
    output logic                  o_head_valid,
    output cts_pkg::t_token       o_head
);

    cts_pkg::t_token                 r_mem [cts_pkg::QUEUE_DEPTH];
    logic [cts_pkg::QIDX_W-1:0]      r_head;
    logic [cts_pkg::QCNT_W-1:0]      r_count;
    logic [cts_pkg::QCNT_W-1:0]      n_count;
    logic [cts_pkg::QIDX_W-1:0]      tail;
    logic [cts_pkg::QIDX_W-1:0]      tail_1;
    logic                            pop;

    // Room for a full pair of tokens
    assign o_room       = r_count <= cts_pkg::QCNT_W'(cts_pkg::QUEUE_DEPTH - 2);
    assign o_head_valid = r_count != '0;
    assign o_head       = r_mem[r_head];
    assign pop          = o_head_valid && i_pop_ready;
    assign tail         = r_head + r_count[cts_pkg::QIDX_W-1:0];
    assign tail_1       = tail + cts_pkg::QIDX_W'(1);
    assign n_count      = r_count + cts_pkg::QCNT_W'(i_push.count)
                        - cts_pkg::QCNT_W'(pop);

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (pop) begin
                r_head <= r_head + cts_pkg::QIDX_W'(1);
            end
        end
    end

    // Store incoming tokens
    always_ff @(posedge i_clk) begin
        if (i_push.count != '0) begin
            r_mem[tail] <= i_push.tok0;
        end
        if (i_push.count == cts_pkg::PUSH_W'(2)) begin
            r_mem[tail_1] <= i_push.tok1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/calculator_token_scanner.sv =====
// ----------------------------------------------------------------------------
// calculator_token_scanner
// Streaming scanner: characters in, tokens of the calculator language out.
// ----------------------------------------------------------------------------
//  Channel   Modport  Beat carries
//  i_char    sink     char_code, end_of_input
//  o_token   source   token_kind, token_line, token_length, literal_value,
//                     token_end_offset, last_result
//
//  One character is taken per cycle while the queue has room; tokens pass
//  through the input register, then the four-entry result queue. A character
//  that yields two tokens sends them one token a beat from that queue.
//  i_char.ready falls while the queue holds more than two tokens and the
//  input register is full; output stalls back up only through that queue.
//  Reset puts the scanner idle at line one, offset zero, queue empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module calculator_token_scanner (
    input  var logic      i_clk,
    input  var logic      i_rst_n,
    cts_char_if.sink      i_char,
    cts_token_if.source   o_token
);

    logic                          r_in_valid;
    logic [cts_pkg::CHAR_W-1:0]    r_in_char;
    logic                          r_in_eof;
    cts_pkg::t_scan_state          r_state;
    cts_pkg::t_scan_state          n_state;
    cts_pkg::t_push                lex_push;
    cts_pkg::t_push                queue_push;
    cts_pkg::t_token               head;
    logic                          room;
    logic                          head_valid;
    logic                          proceed;

    // Input register moves on when the queue can take a full pair
    assign proceed      = r_in_valid && room;
    assign i_char.ready = !r_in_valid || proceed;

    // Hold the input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_char <= i_char.char_code;
            r_in_eof  <= i_char.end_of_input;
        end
    end

    // Scan one character
    cts_lex u_lex (
        .i_state        (r_state),
        .i_char_code    (r_in_char),
        .i_end_of_input (r_in_eof),
        .o_state        (n_state),
        .o_push         (lex_push)
    );

    // Advance scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cts_pkg::SCAN_RESET;
        end else if (proceed) begin
            r_state <= n_state;
        end
    end

    // Drop the tokens when the character is not consumed this cycle
    always_comb begin
        queue_push = lex_push;
        if (!proceed) begin
            queue_push.count = '0;
        end
    end

    cts_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (queue_push),
        .o_room       (room),
        .i_pop_ready  (o_token.ready),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    assign o_token.valid            = head_valid;
    assign o_token.token_kind       = head.token_kind;
    assign o_token.token_line       = head.token_line;
    assign o_token.token_length     = head.token_length;
    assign o_token.literal_value    = head.literal_value;
    assign o_token.token_end_offset = head.token_end_offset;
    assign o_token.last_result      = head.last_result;

endmodule

`default_nettype wire

// ===== rtl/cts_checker.sv =====
// ----------------------------------------------------------------------------
// cts_checker
// Port-level checks on the token channel of the scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "calculator_token_scanner_assert.svh"

module cts_checker (
    input  var logic                         i_clk,
    input  var logic                         i_rst_n,
    input  var logic                         i_valid,
    input  var logic                         i_ready,
    input  var logic [cts_pkg::KIND_W-1:0]   i_kind,
    input  var logic [cts_pkg::LINE_W-1:0]   i_line,
    input  var logic [cts_pkg::LEN_W-1:0]    i_length,
    input  var logic [cts_pkg::LIT_W-1:0]    i_literal,
    input  var logic [cts_pkg::OFF_W-1:0]    i_end_offset,
    input  var logic                         i_last
);

    logic beat;

    assign beat = i_valid && i_ready;

    // A stalled token stays offered
    `CTS_ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid, "token valid dropped while stalled")

    // A stalled token keeps its payload
    `CTS_ASSERT_NEXT(a_payload_hold, i_clk, i_rst_n, i_valid && !i_ready, $stable(i_kind) && $stable(i_line) && $stable(i_length) && $stable(i_literal) && $stable(i_end_offset) && $stable(i_last), "token payload changed while stalled")

    // Line numbers never go back within one stream
    `CTS_ASSERT_NOW(a_line_order, i_clk, i_rst_n, beat && $past(beat) && ($past(i_kind) != cts_pkg::K_END), i_line >= $past(i_line), "token line went backwards")

    // Only literal tokens carry a value
    `CTS_ASSERT_NOW(a_literal_zero, i_clk, i_rst_n, i_valid && (i_kind != cts_pkg::K_LITERAL), i_literal == '0, "non-literal token carries a value")

endmodule

bind calculator_token_scanner cts_checker u_cts_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_token.valid),
    .i_ready      (o_token.ready),
    .i_kind       (o_token.token_kind),
    .i_line       (o_token.token_line),
    .i_length     (o_token.token_length),
    .i_literal    (o_token.literal_value),
    .i_end_offset (o_token.token_end_offset),
    .i_last       (o_token.last_result)
);

`default_nettype wire
